// ----- sv/fen_pkg.sv -----
`timescale 1ns / 1ps

package fen_pkg;

    // Fixed field widths of the item formats.
    localparam int unsigned INDEX_W    = 10;
    localparam int unsigned SIZE_W     = 11;
    localparam int unsigned DATA_W     = 32;
    // Walk index holds position plus one and may step once past the size in use.
    localparam int unsigned WALK_W     = 12;
    // Widest node address that any table depth needs.
    localparam int unsigned ADDR_MAX_W = 16;

    // Command codes.
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_SUM = 1'b1;

    typedef struct packed {
        logic                      command;
        logic [INDEX_W-1:0]        low_index;
        logic [INDEX_W-1:0]        high_index;
        logic signed [DATA_W-1:0]  amount;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  range_sum;
        logic                      index_error;
    } out_item_t;

    // Node store access for one cycle.
    typedef struct packed {
        logic                      wr_en;
        logic [ADDR_MAX_W-1:0]     wr_addr;
        logic [DATA_W-1:0]         wr_data;
        logic                      rd_en;
        logic [ADDR_MAX_W-1:0]     rd_addr;
    } mem_req_t;

endpackage

// ----- sv/fen_node_mem.sv -----
`timescale 1ns / 1ps

module fen_node_mem
    import fen_pkg::*;
#(
    parameter int unsigned DEPTH = 1024
)
(
    input  logic              clk,
    input  mem_req_t          mem_req,
    output logic [DATA_W-1:0] rd_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_W-1:0] node_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            node_mem[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_data_reg <= node_mem[mem_req.rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/fen_seq.sv -----
`timescale 1ns / 1ps

module fen_seq
    import fen_pkg::*;
#(
    parameter int unsigned MAX_POSITIONS = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SIZE_W-1:0] eff_size,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_item,
    output logic              res_valid,
    input  logic              res_ready,
    output out_item_t         res_item,
    output mem_req_t          mem_req,
    input  logic [DATA_W-1:0] mem_rd_data
);

    localparam int unsigned AW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_WALK   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]            state_reg,     state_next;
    logic [AW-1:0]         clr_cnt_reg,   clr_cnt_next;
    logic [WALK_W-1:0]     k_reg,         k_next;
    logic                  cmd_reg,       cmd_next;
    logic                  left_reg,      left_next;
    logic [INDEX_W-1:0]    lo_reg,        lo_next;
    logic [DATA_W-1:0]     amt_reg,       amt_next;
    logic [DATA_W-1:0]     acc_reg,       acc_next;
    logic                  err_reg,       err_next;
    logic                  pend_reg,      pend_next;
    logic [ADDR_MAX_W-1:0] pend_addr_reg, pend_addr_next;

    logic [WALK_W-1:0]     k_lsb;
    logic [WALK_W-1:0]     k_addr;
    logic                  k_ok;
    logic                  lo_bad;
    logic                  hi_bad;
    logic [DATA_W-1:0]     op_a;
    logic [DATA_W-1:0]     op_b;
    logic [DATA_W-1:0]     unit_sum;

    // Lowest set bit of the walk index and the node it addresses.
    assign k_lsb  = k_reg & (~k_reg + WALK_W'(1));
    assign k_addr = k_reg - WALK_W'(1);
    // A prefix walk runs down to zero; an add walk stops past the size in use.
    assign k_ok   = (k_reg != '0) &&
                    ((cmd_reg == CMD_SUM) || (k_reg <= {1'b0, eff_size}));

    assign lo_bad = {1'b0, in_item.low_index} >= eff_size;
    assign hi_bad = {1'b0, in_item.high_index} >= eff_size;

    // Shared adder: node plus amount for an add, accumulate plus or minus node for a sum.
    always_comb
    begin
        if (cmd_reg == CMD_SUM)
        begin
            op_a = acc_reg;
            op_b = left_reg ? ~mem_rd_data : mem_rd_data;
        end
        else
        begin
            op_a = mem_rd_data;
            op_b = amt_reg;
        end
        unit_sum = op_a + op_b + DATA_W'(cmd_reg & left_reg);
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        k_next         = k_reg;
        cmd_next       = cmd_reg;
        left_next      = left_reg;
        lo_next        = lo_reg;
        amt_next       = amt_reg;
        acc_next       = acc_reg;
        err_next       = err_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        mem_req        = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = ADDR_MAX_W'(clr_cnt_reg);
                mem_req.wr_data = '0;
                clr_cnt_next    = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(MAX_POSITIONS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next  = in_item.command;
                    lo_next   = in_item.low_index;
                    amt_next  = in_item.amount;
                    acc_next  = '0;
                    left_next = 1'b0;
                    if (lo_bad || ((in_item.command == CMD_SUM) && hi_bad))
                    begin
                        err_next   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        err_next   = 1'b0;
                        k_next     = (in_item.command == CMD_SUM) ?
                                     WALK_W'(in_item.high_index) + WALK_W'(1) :
                                     WALK_W'(in_item.low_index) + WALK_W'(1);
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                // Issue the next node read while the previous node is used.
                if (k_ok)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ADDR_MAX_W'(k_addr);
                    pend_next       = 1'b1;
                    pend_addr_next  = ADDR_MAX_W'(k_addr);
                    k_next          = (cmd_reg == CMD_SUM) ? k_reg - k_lsb : k_reg + k_lsb;
                end
                if (pend_reg)
                begin
                    if (cmd_reg == CMD_SUM)
                    begin
                        acc_next = unit_sum;
                    end
                    else
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = pend_addr_reg;
                        mem_req.wr_data = unit_sum;
                    end
                end
                // Walk finished and last node used.
                if (!k_ok && !pend_reg)
                begin
                    if (cmd_reg == CMD_ADD)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (!left_reg)
                    begin
                        left_next = 1'b1;
                        k_next    = WALK_W'(lo_reg);
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        cmd_reg       <= cmd_next;
        left_reg      <= left_next;
        lo_reg        <= lo_next;
        amt_reg       <= amt_next;
        acc_reg       <= acc_next;
        err_reg       <= err_next;
        pend_addr_reg <= pend_addr_next;
    end

    assign in_ready             = (state_reg == ST_IDLE);
    assign res_valid            = (state_reg == ST_FINISH);
    assign res_item.range_sum   = acc_reg;
    assign res_item.index_error = err_reg;

endmodule

// ----- sv/fenwick_range_sum_table_unit.sv -----
`timescale 1ns / 1ps

// Binary indexed tree over MAX_POSITIONS signed 32-bit counts. An add item
// (command 0) adds amount at low_index and gives no result; a sum item
// (command 1) gives prefix(high_index) minus prefix(low_index - 1), wrapping.
// An index at or beyond the size in use gives one result with index_error set
// and a zero sum, and changes nothing. Items are handled one at a time through
// a single node memory and one shared adder, one tree node per cycle. An add
// walks the nodes on its upward path; a sum walks the nodes on both prefix
// walks and is done only once its result can move into the output register.
// After reset the node memory is swept to zero, one entry per cycle, over all
// MAX_POSITIONS entries before the first item is taken; the size register may
// be written meanwhile. A finished result waits in an output register while
// the next item is taken.
module fenwick_range_sum_table_unit
    import fen_pkg::*;
#(
    parameter int unsigned MAX_POSITIONS = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_item,
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data
);

    localparam int unsigned SizeClip = (MAX_POSITIONS > 2047) ? 2047 : MAX_POSITIONS;

    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] eff_size;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg,  out_item_next;
    logic              res_valid;
    logic              res_ready;
    out_item_t         res_item;
    mem_req_t          mem_req;
    logic [DATA_W-1:0] mem_rd_data;

    // Size register, saturated to the table depth.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_W'(1024);
        end
        else if (cfg_wr_en)
        begin
            size_reg <= cfg_wr_data;
        end
    end

    assign eff_size = (size_reg > SIZE_W'(SizeClip)) ? SIZE_W'(SizeClip) : size_reg;

    // Output register.
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_item_next  = res_item;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    fen_seq #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .eff_size    (eff_size),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_item    (res_item),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data)
    );

    fen_node_mem #(
        .DEPTH (MAX_POSITIONS)
    ) u_mem (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (mem_rd_data)
    );

endmodule

// ----- tb/sv/fenwick_range_sum_table_unit_tb.sv -----
`timescale 1ns / 1ps

module fenwick_range_sum_table_unit_tb;
    import fen_pkg::*;

    localparam int unsigned TABLE_DEPTH     = 1024;
    localparam int unsigned DRAIN_CYCLES    = 40;
    localparam int unsigned WAIT_LIMIT      = 5000;
    localparam int unsigned PHASES          = 12;
    localparam int unsigned ITEMS_PER_PHASE = 86;
    localparam int unsigned MAX_SHOWN       = 10;
    localparam int unsigned TIMEOUT_NS      = 1000000;

    typedef enum logic {ROW_ITEM, ROW_SIZE} row_kind_t;
    typedef enum logic [1:0] {EXP_MODEL, EXP_ZERO, EXP_FLAG} exp_kind_t;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        row_kind_t         kind;
        in_item_t          item;
        logic [SIZE_W-1:0] size;
        exp_kind_t         chk;
    } dir_row_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    in_item_t          in_item     = '0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    out_item_t         out_item;
    logic              cfg_wr_en   = 1'b0;
    logic [SIZE_W-1:0] cfg_wr_data = '0;

    // Shadow copy of the node store and the size register.
    logic [DATA_W-1:0] shadow_nodes [TABLE_DEPTH];
    logic [SIZE_W-1:0] shadow_size;

    out_item_t   sums_due [$];
    dir_row_t    dir_rows [$];
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned fail_count     = 0;
    int unsigned results_seen   = 0;
    int unsigned items_sent     = 0;
    int unsigned size_writes    = 0;

    fenwick_range_sum_table_unit #(
        .MAX_POSITIONS (TABLE_DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Sizes above the table depth saturate.
    function automatic int unsigned live_size();
        return (shadow_size > TABLE_DEPTH) ? TABLE_DEPTH : 32'(shadow_size);
    endfunction

    // Prefix sum of positions 0..pos, walking down by lowest set bit.
    function automatic logic [DATA_W-1:0] prefix_total(input int unsigned pos);
        logic [DATA_W-1:0] acc;
        int unsigned       k;
        acc = '0;
        k   = pos + 1;
        while (k != 0)
        begin
            acc += shadow_nodes[(k - 1) % TABLE_DEPTH];
            k   -= k & (~k + 1);
        end
        return acc;
    endfunction

    // Upward walk of an add, bounded by the size in use at this moment.
    task automatic tree_add(input int unsigned pos, input logic [DATA_W-1:0] amt);
        int unsigned n;
        int unsigned k;
        n = live_size();
        k = pos + 1;
        while (k != 0 && k <= n)
        begin
            shadow_nodes[(k - 1) % TABLE_DEPTH] += amt;
            k += k & (~k + 1);
        end
    endtask

    // Applies one item to the shadow table and works out its result, if any.
    task automatic fenwick_apply(input in_item_t it, output bit has_res,
                                 output out_item_t res);
        int unsigned       n;
        logic [DATA_W-1:0] right_sum;
        logic [DATA_W-1:0] left_sum;
        n       = live_size();
        has_res = 1'b1;
        res     = '0;
        if (it.command == CMD_ADD)
        begin
            if (32'(it.low_index) >= n)
                res.index_error = 1'b1;
            else
            begin
                tree_add(32'(it.low_index), it.amount);
                has_res = 1'b0;
            end
        end
        else if (32'(it.low_index) >= n || 32'(it.high_index) >= n)
            res.index_error = 1'b1;
        else
        begin
            right_sum = prefix_total(32'(it.high_index));
            left_sum  = (it.low_index == '0) ? '0 : prefix_total(32'(it.low_index) - 1);
            res.range_sum = right_sum - left_sum;
        end
    endtask

    function automatic void put_item(input logic cmd, input int unsigned lo,
                                     input int unsigned hi, input logic [DATA_W-1:0] amt,
                                     input exp_kind_t chk);
        dir_row_t row;
        row.kind            = ROW_ITEM;
        row.item.command    = cmd;
        row.item.low_index  = INDEX_W'(lo);
        row.item.high_index = INDEX_W'(hi);
        row.item.amount     = amt;
        row.size            = '0;
        row.chk             = chk;
        dir_rows            = {dir_rows, row};
    endfunction

    function automatic void put_size(input logic [SIZE_W-1:0] v);
        dir_row_t row;
        row.kind = ROW_SIZE;
        row.item = '0;
        row.size = v;
        row.chk  = EXP_MODEL;
        dir_rows = {dir_rows, row};
    endfunction

    function automatic void set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER:
            begin
                send_idle_pct  = 69;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 69;
            end
            default:
            begin
                send_idle_pct  = 18;
                recv_stall_pct = 18;
            end
        endcase
    endfunction

    // Mostly in-range positions with the ends favored; a few full-range draws.
    function automatic logic [INDEX_W-1:0] pick_index(input int unsigned n);
        int unsigned roll;
        roll = $urandom_range(99);
        if (n == 0 || roll < 8)
            return INDEX_W'($urandom_range(TABLE_DEPTH - 1));
        if (roll < 16)
            return INDEX_W'(n - 1);
        if (roll < 20)
            return '0;
        return INDEX_W'($urandom_range(n - 1));
    endfunction

    function automatic in_item_t random_item(input int unsigned n);
        in_item_t          it;
        logic [INDEX_W-1:0] swap;
        it.command    = ($urandom_range(1) == 0) ? CMD_ADD : CMD_SUM;
        it.low_index  = pick_index(n);
        it.high_index = pick_index(n);
        // Most sums ask for an ordered range; the rest keep the left end past the right.
        if (it.command == CMD_SUM && it.low_index > it.high_index && $urandom_range(99) < 70)
        begin
            swap          = it.low_index;
            it.low_index  = it.high_index;
            it.high_index = swap;
        end
        case ($urandom_range(9))
            0:       it.amount = 32'h7FFF_FFFF;
            1:       it.amount = 32'h8000_0000;
            2:       it.amount = 32'hFFFF_FFFF;
            3, 4:    it.amount = $signed($urandom_range(200)) - 100;
            default: it.amount = $urandom;
        endcase
        return it;
    endfunction

    // Presents one item after a random gap and records what it should produce.
    task automatic send_item(input in_item_t it, input exp_kind_t chk);
        bit        has_res;
        out_item_t res;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        fenwick_apply(it, has_res, res);
        if (chk != EXP_MODEL)
        begin
            res.range_sum   = '0;
            res.index_error = (chk == EXP_FLAG);
            has_res         = 1'b1;
        end
        if (has_res)
            sums_due = {sums_due, res};
        items_sent++;
    endtask

    // Holds the input low until every due result is back, then waits out
    // any add that may still be walking the tree.
    task automatic settle(input int unsigned extra);
        int unsigned waited;
        waited   = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (sums_due.size() != 0 && waited < WAIT_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        shadow_size = v;
        cfg_wr_en   <= 1'b0;
        size_writes++;
    endtask

    // Result side: compare each accepted result, then draw the next ready.
    always @(posedge clk or negedge rst_n)
    begin : result_check
        out_item_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (sums_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                        $display("unexpected result: sum %0d error %0b",
                                 out_item.range_sum, out_item.index_error);
                end
                else
                begin
                    want = sums_due.pop_front();
                    results_seen++;
                    if (out_item.range_sum !== want.range_sum
                        || out_item.index_error !== want.index_error)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_SHOWN)
                            $display({"result %0d: expected sum %0d error %0b, ",
                                      "got sum %0d error %0b"},
                                     results_seen, want.range_sum, want.index_error,
                                     out_item.range_sum, out_item.index_error);
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : stimulus
        logic [SIZE_W-1:0] phase_sizes [PHASES];
        int unsigned       directed_count;
        int unsigned       p;
        int unsigned       i;

        foreach (shadow_nodes[k])
            shadow_nodes[k] = '0;
        shadow_size = 11'd1024;

        // Empty table, then extreme amounts at both ends and a wrapping add.
        put_item(CMD_SUM, 0, 1023, 32'h0, EXP_ZERO);
        put_item(CMD_SUM, 1023, 0, 32'h0, EXP_ZERO);
        put_item(CMD_ADD, 0, 0, 32'h7FFF_FFFF, EXP_MODEL);
        put_item(CMD_ADD, 1023, 1023, 32'h8000_0000, EXP_MODEL);
        put_item(CMD_ADD, 511, 0, 32'hFFFF_FFFF, EXP_MODEL);
        put_item(CMD_ADD, 0, 1023, 32'h1, EXP_MODEL);
        put_item(CMD_SUM, 0, 0, 32'h0, EXP_MODEL);
        put_item(CMD_SUM, 0, 1023, 32'h0, EXP_MODEL);
        put_item(CMD_SUM, 1023, 0, 32'h0, EXP_MODEL);
        put_item(CMD_SUM, 1023, 1023, 32'h0, EXP_MODEL);
        put_item(CMD_SUM, 512, 511, 32'h0, EXP_MODEL);
        // Half size: out-of-range ends on either side are flagged.
        put_size(11'd512);
        put_item(CMD_ADD, 512, 0, 32'h5, EXP_FLAG);
        put_item(CMD_SUM, 0, 512, 32'h0, EXP_FLAG);
        put_item(CMD_SUM, 600, 100, 32'h0, EXP_FLAG);
        put_item(CMD_SUM, 1023, 1023, 32'h0, EXP_FLAG);
        put_item(CMD_ADD, 100, 0, 32'h5, EXP_MODEL);
        // Oversized register saturates; the stored data is kept.
        put_size(11'd2047);
        put_item(CMD_SUM, 0, 1023, 32'h0, EXP_MODEL);
        put_item(CMD_SUM, 100, 1023, 32'h0, EXP_MODEL);
        // Zero size flags everything.
        put_size(11'd0);
        put_item(CMD_ADD, 0, 0, 32'h3, EXP_FLAG);
        put_item(CMD_SUM, 0, 0, 32'h0, EXP_FLAG);
        // Single position.
        put_size(11'd1);
        put_item(CMD_ADD, 0, 0, 32'h3, EXP_MODEL);
        put_item(CMD_SUM, 0, 0, 32'h0, EXP_MODEL);
        put_item(CMD_ADD, 1, 0, 32'h3, EXP_FLAG);
        put_item(CMD_SUM, 0, 1, 32'h0, EXP_FLAG);

        phase_sizes = '{11'd1024, 11'd2047, 11'd1, 11'd2, 11'd17, 11'd0, 11'd1000,
                        11'd513, 11'd64, 11'd1023, 11'd1024, 11'($urandom_range(1, 1024))};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        set_idle(IDLE_BOTH);
        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_SIZE)
            begin
                settle(DRAIN_CYCLES);
                write_size(dir_rows[r].size);
            end
            else
                send_item(dir_rows[r].item, dir_rows[r].chk);
        end
        directed_count = items_sent;

        // Random phases, each with its own size and handshake pattern.
        for (p = 0; p < PHASES; p++)
        begin
            settle(DRAIN_CYCLES);
            write_size(phase_sizes[p]);
            set_idle(idle_mode_t'(p % 4));
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // Once mid-run, the sender holds off until all results are back.
                if (p == 3 && i == 40)
                    settle(0);
                send_item(random_item(live_size()), EXP_MODEL);
            end
        end

        settle(DRAIN_CYCLES);
        if (sums_due.size() != 0)
        begin
            fail_count += sums_due.size();
            $display("%0d expected results never arrived", sums_due.size());
        end

        $display("Sent %0d items (%0d directed) and checked %0d results over %0d size writes,",
                 items_sent, directed_count, results_seen, size_writes);
        $display("with free-running, sender-idle, receiver-stall and mixed handshakes.");
        if (fail_count == 0)
            $display("fenwick_range_sum_table_unit: match");
        else
            $display("fenwick_range_sum_table_unit: mismatch");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Run did not finish in time.");
        $display("fenwick_range_sum_table_unit: mismatch");
        $finish;
    end

endmodule
